// File: src/counting_bloom_filter_macros.svh
// Assertion macros for the counting Bloom filter.
// Used by the top level only; no dependencies.
`ifndef COUNTING_BLOOM_FILTER_MACROS_SVH
`define COUNTING_BLOOM_FILTER_MACROS_SVH
`define CBF_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define CBF_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: src/cbf_pkg.sv
// Shared types and constants for the counting Bloom filter.
// No dependencies.
package cbf_pkg;
    localparam int MaxBuckets = 65536;
    localparam int MaxHashes = 16;
    localparam int MaxBucketBits = 8;
    localparam int IdxW = $clog2(MaxBuckets);
    localparam int HashW = $clog2(MaxHashes);
    localparam logic [31:0] CrcPoly = 32'hEDB88320;

    localparam logic [2:0] REG_BUCKETS = 3'd0;
    localparam logic [2:0] REG_HASHES = 3'd1;
    localparam logic [2:0] REG_SEED = 3'd2;
    localparam logic [2:0] REG_BITS = 3'd3;
    localparam logic [2:0] REG_STOP = 3'd4;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR, S_BYTE, S_MOD, S_READ, S_WAIT, S_UPDATE, S_DONE
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load_byte;
        logic mod_start;
        logic rd;
        logic upd;
        logic finish;
        logic next_hash;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic mod_done;
        logic last_hash;
        logic stop;
    } t_sts;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int j = 0; j < 8; j++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        return r;
    endfunction
endpackage

// File: src/counting_bloom_filter.sv
// Counting Bloom filter: key bytes in, one result per key out.
// Each byte is hashed as it arrives; at a key end each hash runs a
// bit-serial modulo, then a read and update of the counter memory,
// up to the configured number of hashes. After reset a clearing pass
// zeroes all 65536 counters before the first item is accepted.
// Depends on cbf_pkg, cbf_ctrl, cbf_datapath and the macros header.
`include "counting_bloom_filter_macros.svh"
module counting_bloom_filter import cbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_key_byte,
    input  logic        i_key_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_present,
    output logic        o_full_error,
    output logic [31:0] o_entry_count,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    logic [16:0] r_buckets;
    logic [4:0]  r_hashes;
    logic [30:0] r_seed;
    logic [3:0]  r_bits;
    logic        r_stop;
    logic [1:0]  r_kind;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= 17'd65536;
            r_hashes <= 5'd4;
            r_seed <= '0;
            r_bits <= 4'd1;
            r_stop <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BUCKETS: r_buckets <= i_cfg_data[16:0];
                REG_HASHES: r_hashes <= i_cfg_data[4:0];
                REG_SEED: r_seed <= i_cfg_data;
                REG_BITS: r_bits <= i_cfg_data[3:0];
                REG_STOP: r_stop <= i_cfg_data[0];
                default: ;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_cmd.load_byte) r_kind <= i_kind;
    end

    cbf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_key_last(i_key_last),
        .i_out_ready(i_ready), .i_sts(w_sts), .o_ready(o_ready),
        .o_out_valid(o_valid), .o_cmd(w_cmd)
    );
    cbf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_key_byte(i_key_byte),
        .i_kind(r_kind), .i_buckets(r_buckets), .i_hashes(r_hashes), .i_seed(r_seed),
        .i_bits(r_bits), .i_stop_on_full(r_stop), .o_sts(w_sts), .o_present(o_present),
        .o_full_error(o_full_error), .o_entry_count(o_entry_count)
    );

    `CBF_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready, "accept during result")
    `CBF_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_valid, !(o_present && o_full_error), "both flags")
    `CBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_entry_count), "result dropped")
endmodule

// File: src/cbf_mod.sv
// Restoring divider giving a 32-bit value modulo a 17-bit modulus, one bit a cycle.
// Depends on cbf_pkg.
module cbf_mod import cbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [16:0] o_rem
);
    logic [31:0] r_num;
    logic [17:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] w_sh;
    assign w_sh = {r_rem[16:0], r_num[31]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num <= i_num;
                r_rem <= '0;
                r_cnt <= 6'd0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, i_den}) ? w_sh - {1'b0, i_den} : w_sh;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_rem = r_rem[16:0];
endmodule

// File: src/cbf_datapath.sv
// Datapath: CRC registers, modulo unit, counter memory and entry count.
// Depends on cbf_pkg and cbf_mod.
module cbf_datapath import cbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_key_byte,
    input  logic [1:0]  i_kind,
    input  logic [16:0] i_buckets,
    input  logic [4:0]  i_hashes,
    input  logic [30:0] i_seed,
    input  logic [3:0]  i_bits,
    input  logic        i_stop_on_full,
    output t_sts        o_sts,
    output logic        o_present,
    output logic        o_full_error,
    output logic [31:0] o_entry_count
);
    logic [31:0] r_hash [MaxHashes];
    logic        r_open;
    logic [HashW-1:0] r_hi;
    logic [IdxW-1:0]  r_clr;
    logic [IdxW-1:0]  r_idx;
    logic [7:0]  r_mem [MaxBuckets];
    logic [7:0]  r_rd;
    logic        r_pres, r_err;
    logic [31:0] r_cnt;
    logic [31:0] n_cnt;
    logic [16:0] w_m, w_rem;
    logic [4:0]  w_k;
    logic [3:0]  w_b;
    logic [7:0]  w_max;
    logic        w_mdone;

    assign w_m = (i_buckets == 17'd0) ? 17'd1 :
                 (i_buckets > 17'(MaxBuckets)) ? 17'(MaxBuckets) : i_buckets;
    assign w_k = (i_hashes == 5'd0) ? 5'd1 :
                 (i_hashes > 5'(MaxHashes)) ? 5'(MaxHashes) : i_hashes;
    assign w_b = (i_bits == 4'd0) ? 4'd1 :
                 (i_bits > 4'(MaxBucketBits)) ? 4'(MaxBucketBits) : i_bits;
    assign w_max = 8'((9'd1 << w_b) - 9'd1);

    cbf_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.mod_start),
        .i_num(~r_hash[r_hi]), .i_den(w_m), .o_done(w_mdone), .o_rem(w_rem)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (i_kind == KIND_INSERT && !r_err && r_cnt != '1) n_cnt = r_cnt + 32'd1;
        if (i_kind == KIND_DELETE && r_cnt != '0) n_cnt = r_cnt - 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.clear_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.load_byte) r_open <= 1'b1;
            if (i_cmd.finish) begin
                r_open <= 1'b0;
                r_cnt <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            for (int i = 0; i < MaxHashes; i++)
                r_hash[i] <= crc_byte(r_open ? r_hash[i] : ~(32'(i_seed) + 32'(i)),
                                      i_key_byte);
            r_hi <= '0;
            r_pres <= 1'b1;
            r_err <= 1'b0;
        end
        if (w_mdone) r_idx <= w_rem[IdxW-1:0];
        if (i_cmd.next_hash) r_hi <= r_hi + 1'b1;
        if (i_cmd.upd) begin
            if (i_kind == KIND_QUERY && r_rd == 8'd0) r_pres <= 1'b0;
            if (i_kind == KIND_INSERT && r_rd >= w_max && i_stop_on_full) r_err <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) r_mem[r_clr] <= 8'd0;
        else if (i_cmd.upd) begin
            if (i_kind == KIND_INSERT && r_rd < w_max) r_mem[r_idx] <= r_rd + 8'd1;
            if (i_kind == KIND_DELETE && r_rd != 8'd0) r_mem[r_idx] <= r_rd - 8'd1;
        end
        if (i_cmd.rd) r_rd <= r_mem[r_idx];
    end

    assign o_sts.clear_done = (r_clr == '1);
    assign o_sts.mod_done = w_mdone;
    assign o_sts.last_hash = (5'(r_hi) + 5'd1 >= w_k);
    assign o_sts.stop = (i_kind == KIND_QUERY && r_rd == 8'd0) ||
                        (i_kind == KIND_INSERT && r_rd >= w_max && i_stop_on_full) ||
                        (i_kind != KIND_INSERT && i_kind != KIND_DELETE && i_kind != KIND_QUERY);
    assign o_present = (i_kind == KIND_QUERY) && r_pres;
    assign o_full_error = r_err;
    assign o_entry_count = n_cnt;
endmodule

// File: src/cbf_ctrl.sv
// Controller: sequences clearing, byte hashing and per-hash updates.
// Depends on cbf_pkg.
module cbf_ctrl import cbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_key_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) n_state = S_BYTE;
            end
            S_BYTE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_key_last) n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_start = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_sts.mod_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.rd = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                if (i_sts.stop || i_sts.last_hash) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_hash = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_BYTE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
